@@ rtl/yuvpk_pkg.sv @@
// Shared constants, register codes and types of the YUV to RGB pixel packer.
package yuvpk_pkg;

  // Channel and configuration port widths.
  localparam int SAMPLE_W    = 8;
  localparam int WORD_W      = 32;
  localparam int MASK_W      = 4;
  localparam int LANE_W      = 2;
  localparam int FMT_W       = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // Width of the signed accumulation; the blue sum reaches about 137000.
  localparam int SUM_W = 19;
  // Integer part of a sum after dropping the eight fraction bits.
  localparam int INT_W = SUM_W - 8;

  // BT.601 studio-range coefficients in 8-bit fixed point.
  localparam logic signed [SUM_W-1:0] COEF_Y      = SUM_W'(298);
  localparam logic signed [SUM_W-1:0] COEF_R_CR   = SUM_W'(409);
  localparam logic signed [SUM_W-1:0] COEF_G_CB   = SUM_W'(100);
  localparam logic signed [SUM_W-1:0] COEF_G_CR   = SUM_W'(208);
  localparam logic signed [SUM_W-1:0] COEF_B_CB   = SUM_W'(516);
  localparam logic signed [SUM_W-1:0] ROUND_HALF  = SUM_W'(128);
  localparam logic signed [SAMPLE_W:0] LUMA_OFFSET   = 9'sd16;
  localparam logic signed [SAMPLE_W:0] CHROMA_OFFSET = 9'sd128;

  localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [SAMPLE_W-1:0] CHANNEL_MAX  = 8'd255;

  // Pixel format codes.
  localparam logic [FMT_W-1:0] FMT_32BPP       = 2'd0;
  localparam logic [FMT_W-1:0] FMT_24BPP       = 2'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565      = 2'd2;
  localparam logic [FMT_W-1:0] FMT_UNSUPPORTED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_LANE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_LANE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_LANE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_ENABLE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LANE   = 3'd5;

  // Current configuration as seen by the packer.
  typedef struct packed {
    logic [FMT_W-1:0]  pixel_format;
    logic [LANE_W-1:0] red_lane;
    logic [LANE_W-1:0] green_lane;
    logic [LANE_W-1:0] blue_lane;
    logic              alpha_enable;
    logic [LANE_W-1:0] alpha_lane;
  } cfg_t;

  // Converted pixel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } rgb_t;

endpackage

@@ rtl/yuvpk_ifs.sv @@
// Valid/ready channel interfaces for pixels in, packed pixels out and configuration writes.
interface yuvpk_pixel_in_if;
  import yuvpk_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma;
  logic [SAMPLE_W-1:0] chroma_blue;
  logic [SAMPLE_W-1:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink (input valid, input luma, input chroma_blue, input chroma_red,
                output ready);
endinterface

interface yuvpk_pixel_out_if;
  import yuvpk_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   packed_word;
  logic [MASK_W-1:0]   byte_mask;
  logic [SAMPLE_W-1:0] red_value;
  logic [SAMPLE_W-1:0] green_value;
  logic [SAMPLE_W-1:0] blue_value;

  modport source (output valid, output packed_word, output byte_mask, output red_value,
                  output green_value, output blue_value, input ready);
  modport sink (input valid, input packed_word, input byte_mask, input red_value,
                input green_value, input blue_value, output ready);
endinterface

interface yuvpk_cfg_if;
  import yuvpk_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/yuvpk_cfg_regs.sv @@
// Configuration register file of the pixel packer.
module yuvpk_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  yuvpk_cfg_if.sink         cfg,
  output yuvpk_pkg::cfg_t   cfg_state
);
  import yuvpk_pkg::*;

  cfg_t regs;

  // Writes are always taken; an index past the list is dropped.
  assign cfg.ready = 1'b1;
  assign cfg_state = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pixel_format <= FMT_32BPP;
      regs.red_lane     <= 2'd2;
      regs.green_lane   <= 2'd1;
      regs.blue_lane    <= 2'd0;
      regs.alpha_enable <= 1'b1;
      regs.alpha_lane   <= 2'd3;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PIXEL_FORMAT: regs.pixel_format <= cfg.data[FMT_W-1:0];
        REG_RED_LANE:     regs.red_lane     <= cfg.data[LANE_W-1:0];
        REG_GREEN_LANE:   regs.green_lane   <= cfg.data[LANE_W-1:0];
        REG_BLUE_LANE:    regs.blue_lane    <= cfg.data[LANE_W-1:0];
        REG_ALPHA_ENABLE: regs.alpha_enable <= cfg.data[0];
        REG_ALPHA_LANE:   regs.alpha_lane   <= cfg.data[LANE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/yuvpk_convert.sv @@
// BT.601 studio-range YCbCr to RGB888 conversion with rounding and clamping.
module yuvpk_convert (
  input  logic [yuvpk_pkg::SAMPLE_W-1:0] luma,
  input  logic [yuvpk_pkg::SAMPLE_W-1:0] chroma_blue,
  input  logic [yuvpk_pkg::SAMPLE_W-1:0] chroma_red,
  output yuvpk_pkg::rgb_t                rgb
);
  import yuvpk_pkg::*;

  logic signed [SAMPLE_W:0] c_off;
  logic signed [SAMPLE_W:0] u_off;
  logic signed [SAMPLE_W:0] v_off;
  logic signed [SUM_W-1:0]  c_ext;
  logic signed [SUM_W-1:0]  u_ext;
  logic signed [SUM_W-1:0]  v_ext;
  logic signed [SUM_W-1:0]  y_term;
  logic signed [SUM_W-1:0]  r_sum;
  logic signed [SUM_W-1:0]  g_sum;
  logic signed [SUM_W-1:0]  b_sum;

  // Drop the fraction (floor) and limit to 0..255.
  function automatic logic [SAMPLE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
    logic [INT_W-1:0] q;
    q = sum[SUM_W-1:8];
    if (q[INT_W-1]) begin
      clamp_channel = '0;
    end else if (|q[INT_W-2:SAMPLE_W]) begin
      clamp_channel = CHANNEL_MAX;
    end else begin
      clamp_channel = q[SAMPLE_W-1:0];
    end
  endfunction

  always_comb begin
    c_off  = $signed({1'b0, luma}) - LUMA_OFFSET;
    u_off  = $signed({1'b0, chroma_blue}) - CHROMA_OFFSET;
    v_off  = $signed({1'b0, chroma_red}) - CHROMA_OFFSET;
    c_ext  = SUM_W'(c_off);
    u_ext  = SUM_W'(u_off);
    v_ext  = SUM_W'(v_off);
    y_term = c_ext * COEF_Y + ROUND_HALF;
    r_sum  = y_term + v_ext * COEF_R_CR;
    g_sum  = y_term - u_ext * COEF_G_CB - v_ext * COEF_G_CR;
    b_sum  = y_term + u_ext * COEF_B_CB;
    rgb.red   = clamp_channel(r_sum);
    rgb.green = clamp_channel(g_sum);
    rgb.blue  = clamp_channel(b_sum);
  end

endmodule

@@ rtl/yuvpk_pack.sv @@
// Packs an RGB888 pixel into a framebuffer word and byte mask for the configured format.
module yuvpk_pack (
  input  yuvpk_pkg::rgb_t                rgb,
  input  yuvpk_pkg::cfg_t                cfg_state,
  output logic [yuvpk_pkg::WORD_W-1:0]   packed_word,
  output logic [yuvpk_pkg::MASK_W-1:0]   byte_mask
);
  import yuvpk_pkg::*;

  logic alpha_on;

  always_comb begin
    alpha_on    = (cfg_state.pixel_format == FMT_32BPP) && cfg_state.alpha_enable;
    packed_word = '0;
    byte_mask   = '0;
    case (cfg_state.pixel_format)
      FMT_32BPP, FMT_24BPP: begin
        // Each lane takes the highest-priority channel aimed at it:
        // alpha, then blue, then green, then red.
        for (int k = 0; k < MASK_W; k++) begin
          if (alpha_on && cfg_state.alpha_lane == LANE_W'(k)) begin
            packed_word[k*SAMPLE_W +: SAMPLE_W] = ALPHA_OPAQUE;
            byte_mask[k] = 1'b1;
          end else if (cfg_state.blue_lane == LANE_W'(k)) begin
            packed_word[k*SAMPLE_W +: SAMPLE_W] = rgb.blue;
            byte_mask[k] = 1'b1;
          end else if (cfg_state.green_lane == LANE_W'(k)) begin
            packed_word[k*SAMPLE_W +: SAMPLE_W] = rgb.green;
            byte_mask[k] = 1'b1;
          end else if (cfg_state.red_lane == LANE_W'(k)) begin
            packed_word[k*SAMPLE_W +: SAMPLE_W] = rgb.red;
            byte_mask[k] = 1'b1;
          end
        end
      end
      FMT_RGB565: begin
        packed_word = {16'h0, rgb.red[7:3], rgb.green[7:2], rgb.blue[7:3]};
        byte_mask   = 4'b0011;
      end
      FMT_UNSUPPORTED: begin
        packed_word = '0;
        byte_mask   = '0;
      end
      default: begin
        packed_word = '0;
        byte_mask   = '0;
      end
    endcase
  end

endmodule

@@ rtl/yuv_to_rgb_pixel_packer_unit.sv @@
// Top level of the YUV to RGB pixel packer: input register, conversion, packing, result register.

// The block turns one Y/Cb/Cr pixel item into one packed framebuffer item. Conversion uses
// BT.601 studio-range coefficients in 8-bit fixed point, rounds, and clamps each channel to
// 0..255. Packing follows pixel_format: 32 bpp and 24 bpp place red, green and blue in their
// configured byte lanes (32 bpp can add an opaque alpha byte), and where lanes collide alpha
// beats blue, blue beats green and green beats red. 16 bpp gives little-endian RGB565 in the
// low half-word, and the unsupported format gives an all-zero word and mask while the plain
// RGB values are still delivered. Unwritten lanes are always zero. The pipeline has two
// registers, an input register and a result register, with the conversion and lane muxing
// between them, so it takes one item every clock cycle while the output is not stalled. An
// accepted item moves from the input register into the result register and is presented on
// pixel_out from there. The result register separates the two sides: a new item is taken
// while a finished result waits, and only when both registers are full and the output is
// stalled does pixel_in.ready drop. The configuration port is always ready and should only
// be written while no items are in flight; there is no clearing pass after reset.
module yuv_to_rgb_pixel_packer_unit (
  input  logic             clk,
  input  logic             rst,
  yuvpk_pixel_in_if.sink   pixel_in,
  yuvpk_pixel_out_if.source pixel_out,
  yuvpk_cfg_if.sink        cfg
);
  import yuvpk_pkg::*;

  // Input register.
  logic                a_valid;
  logic [SAMPLE_W-1:0] a_luma;
  logic [SAMPLE_W-1:0] a_chroma_blue;
  logic [SAMPLE_W-1:0] a_chroma_red;

  // Result register.
  logic                b_valid;
  logic [WORD_W-1:0]   b_word;
  logic [MASK_W-1:0]   b_mask;
  rgb_t                b_rgb;

  cfg_t                cfg_state;
  rgb_t                rgb;
  logic [WORD_W-1:0]   word;
  logic [MASK_W-1:0]   mask;
  logic                advance_b;
  logic                in_ready;

  yuvpk_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_state (cfg_state)
  );

  yuvpk_convert u_convert (
    .luma        (a_luma),
    .chroma_blue (a_chroma_blue),
    .chroma_red  (a_chroma_red),
    .rgb         (rgb)
  );

  yuvpk_pack u_pack (
    .rgb         (rgb),
    .cfg_state   (cfg_state),
    .packed_word (word),
    .byte_mask   (mask)
  );

  // The result register can load when it is empty or being drained this cycle; the input
  // register can load when it is empty or moving into the result register.
  assign advance_b      = !b_valid || pixel_out.ready;
  assign in_ready       = !a_valid || advance_b;
  assign pixel_in.ready = in_ready;

  assign pixel_out.valid       = b_valid;
  assign pixel_out.packed_word = b_word;
  assign pixel_out.byte_mask   = b_mask;
  assign pixel_out.red_value   = b_rgb.red;
  assign pixel_out.green_value = b_rgb.green;
  assign pixel_out.blue_value  = b_rgb.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= pixel_in.valid;
      end
      if (advance_b) begin
        b_valid <= a_valid;
      end
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (pixel_in.valid && in_ready) begin
      a_luma        <= pixel_in.luma;
      a_chroma_blue <= pixel_in.chroma_blue;
      a_chroma_red  <= pixel_in.chroma_red;
    end
    if (a_valid && advance_b) begin
      b_word <= word;
      b_mask <= mask;
      b_rgb  <= rgb;
    end
  end

  // Both pipeline registers are empty right after reset.
  assert property (@(posedge clk) rst |=> !a_valid && !b_valid)
    else $error("pipeline not empty after reset");

  // An item leaving the input register always lands in the result register.
  assert property (@(posedge clk) disable iff (rst) (a_valid && advance_b) |=> b_valid)
    else $error("item lost between input and result register");

  // With both registers full and the output stalled, no new item may be taken.
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_valid && !pixel_out.ready) |-> !in_ready)
    else $error("input accepted while pipeline is full");

  // Every lane that the mask leaves unwritten holds zero.
  assert property (@(posedge clk) disable iff (rst)
    b_valid |-> ((b_mask[0] || b_word[7:0] == 8'h00) &&
                 (b_mask[1] || b_word[15:8] == 8'h00) &&
                 (b_mask[2] || b_word[23:16] == 8'h00) &&
                 (b_mask[3] || b_word[31:24] == 8'h00)))
    else $error("unwritten byte lane is not zero");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the YUV to RGB pixel packer with its own conversion predictor.
`timescale 1ns / 100ps

module tb_top;
  import yuvpk_pkg::*;

  // Quiet cycles the driver waits for before a register write or a pause, enough to know
  // that nothing is left inside the pipeline.
  localparam int PIPE_QUIET = 3;

  // Indexes past the last register. Writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  // Register contents right after reset.
  localparam cfg_t CFG_AFTER_RESET = '{
    pixel_format: FMT_32BPP,
    red_lane:     2'd2,
    green_lane:   2'd1,
    blue_lane:    2'd0,
    alpha_enable: 1'b1,
    alpha_lane:   2'd3
  };

  // Work the driver takes from its queue: a pixel item, a register write, or a pause
  // in which the sender waits until every expected result has come back.
  typedef enum logic [1:0] {
    JOB_PIXEL,
    JOB_REG_WRITE,
    JOB_WAIT_EMPTY
  } pixel_job_kind_t;

  typedef struct {
    pixel_job_kind_t        kind;
    logic [SAMPLE_W-1:0]    luma;
    logic [SAMPLE_W-1:0]    chroma_blue;
    logic [SAMPLE_W-1:0]    chroma_red;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    int                     gap_pct;
    int                     stall_pct;
  } pixel_job_t;

  // One packed pixel as the block should deliver it.
  typedef struct packed {
    logic [WORD_W-1:0]   packed_word;
    logic [MASK_W-1:0]   byte_mask;
    logic [SAMPLE_W-1:0] red_value;
    logic [SAMPLE_W-1:0] green_value;
    logic [SAMPLE_W-1:0] blue_value;
  } packed_pixel_t;

  logic clk;
  logic rst;

  yuvpk_pixel_in_if  pixel_in_bus ();
  yuvpk_pixel_out_if pixel_out_bus ();
  yuvpk_cfg_if       cfg_bus ();

  yuv_to_rgb_pixel_packer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in_bus),
    .pixel_out (pixel_out_bus),
    .cfg       (cfg_bus)
  );

  pixel_job_t    pending_jobs_q[$];
  packed_pixel_t expected_pixels_q[$];

  // The predictor's own copy of the registers, updated when a write is taken.
  cfg_t model_cfg;

  // Driver bookkeeping: an item or a write is on the bus and not yet taken.
  bit pixel_on_bus;
  bit write_on_bus;
  int quiet_cycles;
  // Chance in percent that the receiver holds ready low in a given cycle.
  int current_stall_pct;
  int error_count;

  // Idling pattern stamped onto every job queued from now on.
  int fill_gap_pct;
  int fill_stall_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Scale a fixed-point sum back to a channel: add half an LSB, drop the eight
  // fraction bits with an arithmetic shift (so negative sums round downward), then
  // clamp to the 8-bit range.
  function automatic logic [SAMPLE_W-1:0] scale_to_channel(int sum);
    int q;
    q = (sum + 128) >>> 8;
    if (q < 0) begin
      return '0;
    end
    if (q > 255) begin
      return CHANNEL_MAX;
    end
    return SAMPLE_W'(q);
  endfunction

  // Convert one Y/Cb/Cr pixel to RGB and pack it the way the current registers say.
  function automatic packed_pixel_t predict_packed_pixel(logic [SAMPLE_W-1:0] y,
                                                         logic [SAMPLE_W-1:0] cb,
                                                         logic [SAMPLE_W-1:0] cr,
                                                         cfg_t setting);
    packed_pixel_t       res;
    int                  c;
    int                  u;
    int                  v;
    int                  n_writes;
    logic [SAMPLE_W-1:0] lane_val[4];
    logic [LANE_W-1:0]   lane_sel[4];
    c = int'(y) - 16;
    u = int'(cb) - 128;
    v = int'(cr) - 128;
    res.red_value   = scale_to_channel(298 * c + 409 * v);
    res.green_value = scale_to_channel(298 * c - 100 * u - 208 * v);
    res.blue_value  = scale_to_channel(298 * c + 516 * u);
    res.packed_word = '0;
    res.byte_mask   = '0;
    if (setting.pixel_format == FMT_32BPP || setting.pixel_format == FMT_24BPP) begin
      // Later writes win on a shared lane: red, then green, then blue, then alpha.
      lane_val[0] = res.red_value;
      lane_sel[0] = setting.red_lane;
      lane_val[1] = res.green_value;
      lane_sel[1] = setting.green_lane;
      lane_val[2] = res.blue_value;
      lane_sel[2] = setting.blue_lane;
      lane_val[3] = ALPHA_OPAQUE;
      lane_sel[3] = setting.alpha_lane;
      n_writes = (setting.pixel_format == FMT_32BPP && setting.alpha_enable) ? 4 : 3;
      for (int k = 0; k < n_writes; k++) begin
        res.packed_word[8 * lane_sel[k] +: 8] = lane_val[k];
        res.byte_mask[lane_sel[k]] = 1'b1;
      end
    end else if (setting.pixel_format == FMT_RGB565) begin
      res.packed_word = {16'h0000, res.red_value[7:3], res.green_value[7:2],
                         res.blue_value[7:3]};
      res.byte_mask   = 4'h3;
    end
    return res;
  endfunction

  task automatic queue_pixel(logic [SAMPLE_W-1:0] y, logic [SAMPLE_W-1:0] cb,
                             logic [SAMPLE_W-1:0] cr);
    pixel_job_t job;
    job.kind        = JOB_PIXEL;
    job.luma        = y;
    job.chroma_blue = cb;
    job.chroma_red  = cr;
    job.index       = '0;
    job.data        = '0;
    job.gap_pct     = fill_gap_pct;
    job.stall_pct   = fill_stall_pct;
    pending_jobs_q.push_back(job);
  endtask

  // The register fields sit in the low bits of the data; the bits above them are
  // filled at random, since the block must ignore them.
  task automatic queue_setting(logic [CFG_INDEX_W-1:0] idx, logic [1:0] field);
    pixel_job_t job;
    job.kind        = JOB_REG_WRITE;
    job.luma        = '0;
    job.chroma_blue = '0;
    job.chroma_red  = '0;
    job.index       = idx;
    job.data        = CFG_DATA_W'($urandom);
    job.data[1:0]   = field;
    job.gap_pct     = fill_gap_pct;
    job.stall_pct   = fill_stall_pct;
    pending_jobs_q.push_back(job);
  endtask

  task automatic queue_wait_empty();
    pixel_job_t job;
    job.kind        = JOB_WAIT_EMPTY;
    job.luma        = '0;
    job.chroma_blue = '0;
    job.chroma_red  = '0;
    job.index       = '0;
    job.data        = '0;
    job.gap_pct     = fill_gap_pct;
    job.stall_pct   = fill_stall_pct;
    pending_jobs_q.push_back(job);
  endtask

  // Mostly uniform samples, with a share taken from the range edges, the studio-range edges and the midpoint.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(5))
        0:       return 8'd0;
        1:       return 8'd255;
        2:       return 8'd16;
        3:       return 8'd235;
        4:       return 8'd128;
        default: return 8'd240;
      endcase
    end
    return SAMPLE_W'($urandom);
  endfunction

  // Driver. A job is taken from the queue only when nothing is on the bus; a pixel
  // item stays on the bus until it is taken, and register writes and waits hold
  // off until the pipeline has been quiet long enough to be empty.
  always @(posedge clk) begin : drive_proc
    pixel_job_t job;
    bit         start_pixel;
    bit         start_write;
    if (rst) begin
      pixel_in_bus.valid       <= 1'b0;
      pixel_in_bus.luma        <= '0;
      pixel_in_bus.chroma_blue <= '0;
      pixel_in_bus.chroma_red  <= '0;
      cfg_bus.valid            <= 1'b0;
      cfg_bus.index            <= '0;
      cfg_bus.data             <= '0;
      pixel_on_bus = 1'b0;
      write_on_bus = 1'b0;
      quiet_cycles = 0;
      model_cfg    = CFG_AFTER_RESET;
    end else begin
      start_pixel = 1'b0;
      start_write = 1'b0;
      // An item taken at this edge is predicted with the registers as they stand.
      if (pixel_in_bus.valid && pixel_in_bus.ready) begin
        expected_pixels_q.push_back(predict_packed_pixel(pixel_in_bus.luma,
                                                         pixel_in_bus.chroma_blue,
                                                         pixel_in_bus.chroma_red,
                                                         model_cfg));
        pixel_on_bus = 1'b0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_PIXEL_FORMAT: model_cfg.pixel_format = cfg_bus.data[FMT_W-1:0];
          REG_RED_LANE:     model_cfg.red_lane     = cfg_bus.data[LANE_W-1:0];
          REG_GREEN_LANE:   model_cfg.green_lane   = cfg_bus.data[LANE_W-1:0];
          REG_BLUE_LANE:    model_cfg.blue_lane    = cfg_bus.data[LANE_W-1:0];
          REG_ALPHA_ENABLE: model_cfg.alpha_enable = cfg_bus.data[0];
          REG_ALPHA_LANE:   model_cfg.alpha_lane   = cfg_bus.data[LANE_W-1:0];
          default: ;
        endcase
        write_on_bus = 1'b0;
      end
      if (expected_pixels_q.size() == 0 && !pixel_on_bus && !write_on_bus) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      if (!pixel_on_bus && !write_on_bus && pending_jobs_q.size() != 0) begin
        job = pending_jobs_q[0];
        case (job.kind)
          JOB_PIXEL: begin
            if ($urandom_range(99) >= job.gap_pct) begin
              void'(pending_jobs_q.pop_front());
              current_stall_pct = job.stall_pct;
              start_pixel = 1'b1;
            end
          end
          JOB_REG_WRITE: begin
            if (quiet_cycles >= PIPE_QUIET) begin
              void'(pending_jobs_q.pop_front());
              start_write = 1'b1;
            end
          end
          default: begin
            if (quiet_cycles >= PIPE_QUIET) begin
              void'(pending_jobs_q.pop_front());
              current_stall_pct = job.stall_pct;
            end
          end
        endcase
      end
      if (start_pixel) begin
        pixel_in_bus.luma        <= job.luma;
        pixel_in_bus.chroma_blue <= job.chroma_blue;
        pixel_in_bus.chroma_red  <= job.chroma_red;
        pixel_on_bus = 1'b1;
      end
      if (start_write) begin
        cfg_bus.index <= job.index;
        cfg_bus.data  <= job.data;
        write_on_bus = 1'b1;
      end
      // Each valid gets exactly one assignment per edge, so a held item never dips.
      pixel_in_bus.valid <= pixel_on_bus;
      cfg_bus.valid      <= write_on_bus;
    end
  end

  // Monitor. Every result taken is matched against the oldest expectation, field by
  // field; ready is redrawn every cycle from the current stall chance.
  always @(posedge clk) begin : check_proc
    packed_pixel_t want;
    if (rst) begin
      pixel_out_bus.ready <= 1'b0;
    end else begin
      if (pixel_out_bus.valid && pixel_out_bus.ready) begin
        if (expected_pixels_q.size() == 0) begin
          $error("result item with no expectation: packed_word %h byte_mask %h",
                 pixel_out_bus.packed_word, pixel_out_bus.byte_mask);
          error_count++;
        end else begin
          want = expected_pixels_q.pop_front();
          if (pixel_out_bus.packed_word !== want.packed_word) begin
            $error("packed_word: expected %h, actual %h", want.packed_word,
                   pixel_out_bus.packed_word);
            error_count++;
          end
          if (pixel_out_bus.byte_mask !== want.byte_mask) begin
            $error("byte_mask: expected %h, actual %h", want.byte_mask,
                   pixel_out_bus.byte_mask);
            error_count++;
          end
          if (pixel_out_bus.red_value !== want.red_value) begin
            $error("red_value: expected %0d, actual %0d", want.red_value,
                   pixel_out_bus.red_value);
            error_count++;
          end
          if (pixel_out_bus.green_value !== want.green_value) begin
            $error("green_value: expected %0d, actual %0d", want.green_value,
                   pixel_out_bus.green_value);
            error_count++;
          end
          if (pixel_out_bus.blue_value !== want.blue_value) begin
            $error("blue_value: expected %0d, actual %0d", want.blue_value,
                   pixel_out_bus.blue_value);
            error_count++;
          end
        end
      end
      pixel_out_bus.ready <= ($urandom_range(99) >= current_stall_pct);
    end
  end

  // Stimulus and end of run.
  initial begin : stim_proc
    int gap_by_phase[4];
    int stall_by_phase[4];
    int mode;
    // Every input is known from time zero; reset holds until reset_proc releases it.
    rst                      = 1'b1;
    pixel_in_bus.valid       = 1'b0;
    pixel_in_bus.luma        = '0;
    pixel_in_bus.chroma_blue = '0;
    pixel_in_bus.chroma_red  = '0;
    pixel_out_bus.ready      = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = '0;
    cfg_bus.data             = '0;
    error_count       = 0;
    current_stall_pct = 0;
    fill_gap_pct      = 0;
    fill_stall_pct    = 0;

    // Idling phases: none, sender idle, receiver stalling, and both together.
    gap_by_phase   = '{0, 68, 0, 17};
    stall_by_phase = '{0, 0, 68, 17};

    // Directed part, default registers first: the corners of the input range,
    // studio black and white, values past the studio range that must clamp high or
    // low, and near-primary colors.
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd16, 8'd128, 8'd128);
    queue_pixel(8'd235, 8'd128, 8'd128);
    queue_pixel(8'd255, 8'd128, 8'd128);
    queue_pixel(8'd0, 8'd128, 8'd128);
    queue_pixel(8'd82, 8'd90, 8'd240);
    queue_pixel(8'd145, 8'd54, 8'd34);
    queue_pixel(8'd41, 8'd240, 8'd110);
    queue_pixel(8'd128, 8'd0, 8'd255);
    queue_pixel(8'd128, 8'd255, 8'd0);

    // 24 bpp with red moved to lane 3, which is written like any other lane.
    queue_setting(REG_PIXEL_FORMAT, FMT_24BPP);
    queue_setting(REG_RED_LANE, 2'd3);
    queue_pixel(8'd200, 8'd50, 8'd200);

    // RGB565 in the low half-word.
    queue_setting(REG_PIXEL_FORMAT, FMT_RGB565);
    queue_pixel(8'd255, 8'd128, 8'd128);
    queue_pixel(8'd81, 8'd90, 8'd240);

    // Unsupported format: no bytes written, channels still reported.
    queue_setting(REG_PIXEL_FORMAT, FMT_UNSUPPORTED);
    queue_pixel(8'd128, 8'd128, 8'd128);

    // Every channel and alpha on lane 0: alpha must win.
    queue_setting(REG_PIXEL_FORMAT, FMT_32BPP);
    queue_setting(REG_RED_LANE, 2'd0);
    queue_setting(REG_GREEN_LANE, 2'd0);
    queue_setting(REG_BLUE_LANE, 2'd0);
    queue_setting(REG_ALPHA_LANE, 2'd0);
    queue_pixel(8'd180, 8'd60, 8'd200);

    // Same collision with alpha off: blue must win.
    queue_setting(REG_ALPHA_ENABLE, 2'b10);
    queue_pixel(8'd180, 8'd60, 8'd200);

    // Red and green share lane 3 and green wins; alpha lane 3 is unused with alpha off.
    queue_setting(REG_RED_LANE, 2'd3);
    queue_setting(REG_GREEN_LANE, 2'd3);
    queue_setting(REG_ALPHA_LANE, 2'd3);
    queue_pixel(8'd100, 8'd200, 8'd30);

    // Writes past the last register must leave the packing as it was.
    queue_setting(REG_SPARE_LO, 2'd3);
    queue_setting(REG_SPARE_HI, 2'd3);
    queue_pixel(8'd100, 8'd200, 8'd30);

    // Random part: ten segments of a hundred items, each under fresh registers and
    // one idling phase, with a pause mid-segment until every result is back.
    for (int seg = 0; seg < 10; seg++) begin
      mode           = seg % 4;
      fill_gap_pct   = gap_by_phase[mode];
      fill_stall_pct = stall_by_phase[mode];
      if (seg == 4) begin
        // Extreme: full collision on lane 0 with alpha.
        queue_setting(REG_PIXEL_FORMAT, FMT_32BPP);
        queue_setting(REG_RED_LANE, 2'd0);
        queue_setting(REG_GREEN_LANE, 2'd0);
        queue_setting(REG_BLUE_LANE, 2'd0);
        queue_setting(REG_ALPHA_ENABLE, 2'b01);
        queue_setting(REG_ALPHA_LANE, 2'd0);
      end else if (seg == 5) begin
        // Extreme: everything on lane 3 in 24 bpp.
        queue_setting(REG_PIXEL_FORMAT, FMT_24BPP);
        queue_setting(REG_RED_LANE, 2'd3);
        queue_setting(REG_GREEN_LANE, 2'd3);
        queue_setting(REG_BLUE_LANE, 2'd3);
        queue_setting(REG_ALPHA_ENABLE, 2'b11);
        queue_setting(REG_ALPHA_LANE, 2'd3);
      end else begin
        queue_setting(REG_PIXEL_FORMAT, 2'($urandom_range(3)));
        queue_setting(REG_RED_LANE, 2'($urandom_range(3)));
        queue_setting(REG_GREEN_LANE, 2'($urandom_range(3)));
        queue_setting(REG_BLUE_LANE, 2'($urandom_range(3)));
        queue_setting(REG_ALPHA_ENABLE, 2'($urandom_range(3)));
        queue_setting(REG_ALPHA_LANE, 2'($urandom_range(3)));
      end
      for (int n = 0; n < 100; n++) begin
        if (n == 50) begin
          queue_wait_empty();
        end
        queue_pixel(pick_sample(), pick_sample(), pick_sample());
      end
    end

    @(negedge rst);
    while (pending_jobs_q.size() != 0 || pixel_on_bus || write_on_bus ||
           expected_pixels_q.size() != 0) begin
      @(posedge clk);
    end
    // Give a stray extra result time to show up before the verdict.
    repeat (PIPE_QUIET * 4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Reset release, as a nonblocking update at the edge like every other input.
  initial begin : reset_proc
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : limit_proc
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
